// ===== rtl/obuhd_pkg.sv =====
// shared constants, codes and types of the unit header deframer
package obuhd_pkg;

    // longest leb128 field in bytes
    localparam int LEB_MAX_BYTES = 8;
    localparam int LEB_CNT_W     = 4;

    // parse phase codes, also the byte kind reported on the output
    localparam logic [2:0] PH_HDR     = 3'd0;
    localparam logic [2:0] PH_SIZE    = 3'd1;
    localparam logic [2:0] PH_TRIM    = 3'd2;
    localparam logic [2:0] PH_EXTSIZE = 3'd3;
    localparam logic [2:0] PH_EXTDATA = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;

    // configuration register indexes (byte address = 4 * index)
    localparam int          APB_AW         = 5;
    localparam logic [2:0]  REG_PROFILE    = 3'd0;
    localparam logic [2:0]  REG_AUDIO_LO   = 3'd1;
    localparam logic [2:0]  REG_AUDIO_HI   = 3'd2;
    localparam logic [2:0]  REG_RSVD_LO    = 3'd3;
    localparam logic [2:0]  REG_RSVD_HI    = 3'd4;
    localparam logic [2:0]  REG_META       = 3'd5;
    localparam logic [2:0]  REG_MAX_SIZE   = 3'd6;

    // reset values
    localparam logic [2:0]  RST_PROFILE    = 3'd0;
    localparam logic [4:0]  RST_AUDIO_LO   = 5'd5;
    localparam logic [4:0]  RST_AUDIO_HI   = 5'd23;
    localparam logic [4:0]  RST_RSVD_LO    = 5'd25;
    localparam logic [4:0]  RST_RSVD_HI    = 5'd30;
    localparam logic [4:0]  RST_META       = 5'd24;
    localparam logic [31:0] RST_MAX_SIZE   = 32'd2097152;

    // highest profile at which metadata units count as reserved
    localparam logic [2:0]  META_RSVD_PROFILE = 3'd2;

    typedef struct packed {
        logic [2:0]  profile;
        logic [4:0]  audio_first_type;
        logic [4:0]  audio_last_type;
        logic [4:0]  reserved_first_type;
        logic [4:0]  reserved_last_type;
        logic [4:0]  metadata_type;
        logic [31:0] max_unit_size;
    } cfg_t;

endpackage

// ===== rtl/obuhd_regs.sv =====
// apb configuration registers of the unit header deframer
module obuhd_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [obuhd_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output obuhd_pkg::cfg_t            cfg
);

    obuhd_pkg::cfg_t cfg_reg;
    logic            wr_en;
    logic [2:0]      reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.profile             <= obuhd_pkg::RST_PROFILE;
            cfg_reg.audio_first_type    <= obuhd_pkg::RST_AUDIO_LO;
            cfg_reg.audio_last_type     <= obuhd_pkg::RST_AUDIO_HI;
            cfg_reg.reserved_first_type <= obuhd_pkg::RST_RSVD_LO;
            cfg_reg.reserved_last_type  <= obuhd_pkg::RST_RSVD_HI;
            cfg_reg.metadata_type       <= obuhd_pkg::RST_META;
            cfg_reg.max_unit_size       <= obuhd_pkg::RST_MAX_SIZE;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                obuhd_pkg::REG_PROFILE:  cfg_reg.profile             <= pwdata[2:0];
                obuhd_pkg::REG_AUDIO_LO: cfg_reg.audio_first_type    <= pwdata[4:0];
                obuhd_pkg::REG_AUDIO_HI: cfg_reg.audio_last_type     <= pwdata[4:0];
                obuhd_pkg::REG_RSVD_LO:  cfg_reg.reserved_first_type <= pwdata[4:0];
                obuhd_pkg::REG_RSVD_HI:  cfg_reg.reserved_last_type  <= pwdata[4:0];
                obuhd_pkg::REG_META:     cfg_reg.metadata_type       <= pwdata[4:0];
                obuhd_pkg::REG_MAX_SIZE: cfg_reg.max_unit_size       <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            obuhd_pkg::REG_PROFILE:  prdata = {29'd0, cfg_reg.profile};
            obuhd_pkg::REG_AUDIO_LO: prdata = {27'd0, cfg_reg.audio_first_type};
            obuhd_pkg::REG_AUDIO_HI: prdata = {27'd0, cfg_reg.audio_last_type};
            obuhd_pkg::REG_RSVD_LO:  prdata = {27'd0, cfg_reg.reserved_first_type};
            obuhd_pkg::REG_RSVD_HI:  prdata = {27'd0, cfg_reg.reserved_last_type};
            obuhd_pkg::REG_META:     prdata = {27'd0, cfg_reg.metadata_type};
            obuhd_pkg::REG_MAX_SIZE: prdata = cfg_reg.max_unit_size;
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/obu_header_deframer_core.sv =====
// unit header deframer: byte-wise header parse, leb128 decode and payload framing
// Takes one stream byte per cycle and returns one tagged result word per byte in the cycle
// after acceptance; a new byte is taken in every cycle that the result register is empty
// or being emptied, so the sustained rate is one byte per clock. The whole per-byte update
// (leb128 shift-or, unit and skip countdowns, header decode) sits between the parse state
// registers and the result register. Header fields and trim counts stay on the outputs
// until the next header byte; resync restarts parsing at the byte that carries it.
module obu_header_deframer_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [obuhd_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   data_byte,
    input  logic                         resync,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   byte_out,
    output logic [2:0]                   byte_kind,
    output logic [4:0]                   unit_type,
    output logic                         redundant_copy,
    output logic                         trimming_flag,
    output logic [31:0]                  trim_at_end,
    output logic [31:0]                  trim_at_start,
    output logic [31:0]                  unit_size,
    output logic                         header_done,
    output logic                         unit_end,
    output logic                         is_reserved,
    output logic                         size_error
);

    obuhd_pkg::cfg_t cfg;

    obuhd_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // parse state
    logic [2:0]                      phase_reg, phase_next;
    logic [31:0]                     leb_accum_reg, leb_accum_next;
    logic [obuhd_pkg::LEB_CNT_W-1:0] leb_bytes_reg, leb_bytes_next;
    logic [31:0]                     bytes_left_reg, bytes_left_next;
    logic [31:0]                     skip_left_reg, skip_left_next;
    logic [4:0]                      type_reg, type_next;
    logic [2:0]                      flag_reg, flag_next;
    logic [31:0]                     trim_end_reg, trim_end_next;
    logic [31:0]                     trim_start_reg, trim_start_next;
    logic [31:0]                     size_reg, size_next;
    logic                            trim_index_reg, trim_index_next;
    logic                            over_max_reg, over_max_next;
    logic                            overrun_reg, overrun_next;

    // result word
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg;
    logic [2:0]  kind_reg, kind_next;
    logic        hdone_reg, hdone_next;
    logic        uend_reg, uend_next;
    logic        rsvd_reg, rsvd_next;

    logic                            take;
    logic [2:0]                      ph;
    logic [4:0]                      shamt;
    logic [31:0]                     leb_add;
    logic [31:0]                     leb_val;
    logic [obuhd_pkg::LEB_CNT_W-1:0] leb_cnt_inc;
    logic                            leb_last;
    logic                            is_audio;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;
    assign ph       = resync ? obuhd_pkg::PH_HDR : phase_reg;

    // leb128 byte contribution, only the low 32 bits survive
    assign shamt       = {2'b00, leb_bytes_reg[2:0]} * 5'd7;
    assign leb_add     = (leb_bytes_reg <= obuhd_pkg::LEB_CNT_W'(4))
                         ? ({25'd0, data_byte[6:0]} << shamt) : 32'd0;
    assign leb_val     = leb_accum_reg | leb_add;
    assign leb_cnt_inc = leb_bytes_reg + obuhd_pkg::LEB_CNT_W'(1);
    assign leb_last    = !data_byte[7]
                         || (leb_cnt_inc >= obuhd_pkg::LEB_CNT_W'(obuhd_pkg::LEB_MAX_BYTES));

    assign is_audio = (type_reg >= cfg.audio_first_type) && (type_reg <= cfg.audio_last_type);

    always_comb
    begin
        phase_next      = ph;
        leb_accum_next  = leb_accum_reg;
        leb_bytes_next  = leb_bytes_reg;
        bytes_left_next = bytes_left_reg;
        skip_left_next  = skip_left_reg;
        type_next       = type_reg;
        flag_next       = flag_reg;
        trim_end_next   = trim_end_reg;
        trim_start_next = trim_start_reg;
        size_next       = size_reg;
        trim_index_next = trim_index_reg;
        over_max_next   = over_max_reg;
        overrun_next    = overrun_reg;
        kind_next       = ph;
        hdone_next      = 1'b0;
        uend_next       = 1'b0;

        // header fields consume unit bytes
        if (ph == obuhd_pkg::PH_TRIM || ph == obuhd_pkg::PH_EXTSIZE
            || ph == obuhd_pkg::PH_EXTDATA)
        begin
            if (bytes_left_reg == 32'd0)
                overrun_next = 1'b1;
            else
                bytes_left_next = bytes_left_reg - 32'd1;
        end

        // leb128 field accumulation
        if (ph == obuhd_pkg::PH_SIZE || ph == obuhd_pkg::PH_TRIM
            || ph == obuhd_pkg::PH_EXTSIZE)
        begin
            if (leb_last)
            begin
                leb_accum_next = 32'd0;
                leb_bytes_next = '0;
            end
            else
            begin
                leb_accum_next = leb_val;
                leb_bytes_next = leb_cnt_inc;
            end
        end

        unique case (ph)
            obuhd_pkg::PH_SIZE:
            begin
                if (leb_last)
                begin
                    size_next       = leb_val;
                    bytes_left_next = leb_val;
                    over_max_next   = leb_val > cfg.max_unit_size;
                    if (is_audio && flag_reg[1])
                    begin
                        phase_next      = obuhd_pkg::PH_TRIM;
                        trim_index_next = 1'b0;
                    end
                    else if (flag_reg[0])
                        phase_next = obuhd_pkg::PH_EXTSIZE;
                    else
                    begin
                        hdone_next = 1'b1;
                        uend_next  = (leb_val == 32'd0);
                        phase_next = (leb_val == 32'd0) ? obuhd_pkg::PH_HDR
                                                        : obuhd_pkg::PH_PAYLOAD;
                    end
                end
            end
            obuhd_pkg::PH_TRIM:
            begin
                if (leb_last)
                begin
                    if (!trim_index_reg)
                    begin
                        trim_end_next   = leb_val;
                        trim_index_next = 1'b1;
                    end
                    else
                    begin
                        trim_start_next = leb_val;
                        trim_index_next = 1'b0;
                        if (flag_reg[0])
                            phase_next = obuhd_pkg::PH_EXTSIZE;
                        else
                        begin
                            hdone_next = 1'b1;
                            uend_next  = (bytes_left_next == 32'd0);
                            phase_next = (bytes_left_next == 32'd0) ? obuhd_pkg::PH_HDR
                                                                    : obuhd_pkg::PH_PAYLOAD;
                        end
                    end
                end
            end
            obuhd_pkg::PH_EXTSIZE:
            begin
                if (leb_last)
                begin
                    skip_left_next = leb_val;
                    if (leb_val == 32'd0)
                    begin
                        hdone_next = 1'b1;
                        uend_next  = (bytes_left_next == 32'd0);
                        phase_next = (bytes_left_next == 32'd0) ? obuhd_pkg::PH_HDR
                                                                : obuhd_pkg::PH_PAYLOAD;
                    end
                    else
                        phase_next = obuhd_pkg::PH_EXTDATA;
                end
            end
            obuhd_pkg::PH_EXTDATA:
            begin
                if (skip_left_reg > 32'd1 - 32'd0 && skip_left_reg != 32'd1)
                    skip_left_next = skip_left_reg - 32'd1;
                else
                begin
                    // last skipped byte (or an empty skip count) closes the header
                    skip_left_next = 32'd0;
                    hdone_next     = 1'b1;
                    uend_next      = (bytes_left_next == 32'd0);
                    phase_next     = (bytes_left_next == 32'd0) ? obuhd_pkg::PH_HDR
                                                                : obuhd_pkg::PH_PAYLOAD;
                end
            end
            obuhd_pkg::PH_PAYLOAD:
            begin
                if (bytes_left_reg > 32'd1)
                    bytes_left_next = bytes_left_reg - 32'd1;
                else
                begin
                    bytes_left_next = 32'd0;
                    uend_next       = 1'b1;
                    phase_next      = obuhd_pkg::PH_HDR;
                end
            end
            default:
            begin
                // header byte, also any unused phase code
                kind_next       = obuhd_pkg::PH_HDR;
                type_next       = data_byte[7:3];
                flag_next       = data_byte[2:0];
                trim_end_next   = 32'd0;
                trim_start_next = 32'd0;
                size_next       = 32'd0;
                bytes_left_next = 32'd0;
                skip_left_next  = 32'd0;
                trim_index_next = 1'b0;
                leb_accum_next  = 32'd0;
                leb_bytes_next  = '0;
                over_max_next   = 1'b0;
                overrun_next    = 1'b0;
                phase_next      = obuhd_pkg::PH_SIZE;
            end
        endcase

        rsvd_next = ((type_next >= cfg.reserved_first_type)
                     && (type_next <= cfg.reserved_last_type))
                    || ((cfg.profile <= obuhd_pkg::META_RSVD_PROFILE)
                        && (type_next == cfg.metadata_type));
        if (over_max_next)
            rsvd_next = 1'b0;
    end

    assign out_valid_next = take || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= obuhd_pkg::PH_HDR;
            leb_accum_reg  <= 32'd0;
            leb_bytes_reg  <= '0;
            bytes_left_reg <= 32'd0;
            skip_left_reg  <= 32'd0;
            type_reg       <= 5'd0;
            flag_reg       <= 3'd0;
            trim_end_reg   <= 32'd0;
            trim_start_reg <= 32'd0;
            size_reg       <= 32'd0;
            trim_index_reg <= 1'b0;
            over_max_reg   <= 1'b0;
            overrun_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg      <= phase_next;
                leb_accum_reg  <= leb_accum_next;
                leb_bytes_reg  <= leb_bytes_next;
                bytes_left_reg <= bytes_left_next;
                skip_left_reg  <= skip_left_next;
                type_reg       <= type_next;
                flag_reg       <= flag_next;
                trim_end_reg   <= trim_end_next;
                trim_start_reg <= trim_start_next;
                size_reg       <= size_next;
                trim_index_reg <= trim_index_next;
                over_max_reg   <= over_max_next;
                overrun_reg    <= overrun_next;
            end
        end
    end

    // result word payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg  <= data_byte;
            kind_reg  <= kind_next;
            hdone_reg <= hdone_next;
            uend_reg  <= uend_next;
            rsvd_reg  <= rsvd_next;
        end
    end

    // header fields held in the parse state only change when a new word is taken
    assign out_valid      = out_valid_reg;
    assign byte_out       = byte_reg;
    assign byte_kind      = kind_reg;
    assign unit_type      = type_reg;
    assign redundant_copy = flag_reg[2];
    assign trimming_flag  = flag_reg[1];
    assign trim_at_end    = trim_end_reg;
    assign trim_at_start  = trim_start_reg;
    assign unit_size      = size_reg;
    assign header_done    = hdone_reg;
    assign unit_end       = uend_reg;
    assign is_reserved    = rsvd_reg;
    assign size_error     = over_max_reg || overrun_reg;

endmodule

// ===== rtl/obuhd_checker.sv =====
// port-level checks of the unit header deframer, bound to the top level
module obuhd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] byte_out,
    input logic [2:0] byte_kind,
    input logic       header_done,
    input logic       unit_end
);

    // an empty result register never holds off the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // every accepted byte leaves a result word behind
    a_word_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted byte produced no result word");

    // a header byte never completes a header or a unit
    a_hdr_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_kind == obuhd_pkg::PH_HDR) |-> (!header_done && !unit_end))
        else $error("header word flagged as header or unit end");

    // header completion only on a size, trim, extension word
    a_hdone_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && header_done) |-> (byte_kind != obuhd_pkg::PH_PAYLOAD))
        else $error("header done on a payload word");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(byte_out) && $stable(byte_kind)))
        else $error("result word changed while stalled");

endmodule

bind obu_header_deframer_core obuhd_checker u_obuhd_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .byte_out    (byte_out),
    .byte_kind   (byte_kind),
    .header_done (header_done),
    .unit_end    (unit_end)
);
